// ===== rtl/matrix_multiply_small_macros.svh =====
// Assertion macros for the matrix product block.
// Needs aclk and aresetn in the scope of each use.
`ifndef MATRIX_MULTIPLY_SMALL_MACROS_SVH
`define MATRIX_MULTIPLY_SMALL_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define MMS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define MMS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mms_pkg.sv =====
// Shared types and constants for the matrix product block.
// No dependencies.
package mms_pkg;

    localparam int DIM    = 3;
    localparam int CELLS  = DIM * DIM;
    localparam int IDX_W  = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = $clog2(2 * CELLS);

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    typedef logic signed [15:0] elem_t;
    typedef logic signed [31:0] prod_t;
    typedef logic signed [32:0] acc_t;

    localparam idx_t  IDX_MAX   = IDX_W'(DIM - 1);
    localparam addr_t DIM_ADDR  = ADDR_W'(DIM);
    localparam cnt_t  CNT_CELLS = CNT_W'(CELLS);
    localparam cnt_t  CNT_LAST  = CNT_W'(2 * CELLS - 1);

    // Tag that travels with each multiply-accumulate through the pipe.
    typedef struct packed {
        logic valid;
        logic first;      // first term of a dot product
        logic last_k;     // last term of a dot product
        idx_t row;
        idx_t col;
        logic last_elem;  // final element of the product matrix
    } mms_tag_t;

endpackage

// ===== rtl/matrix_multiply_small.sv =====
// Matrix product C = A x B, DIM x DIM signed 16-bit elements, one element per input word.
// Loading: one word per cycle; DIM*DIM words of A then DIM*DIM of B (row-major).
// Compute: DIM^3 multiply-accumulates on one shared MAC, one per cycle unless the output
// stalls; each term passes the operand read, product and output registers in turn.
// A 3x3 matrix is loaded as 18 words.
// Reset (aresetn low, synchronous): load counter, sequencer state, pipe tags and output valid clear.
module matrix_multiply_small (
    input  logic        aclk,
    input  logic        aresetn,
    // input word channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_element_value,
    // result word channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [32:0] m_product_value,
    output logic [1:0]  m_row_index,
    output logic [1:0]  m_col_index,
    output logic        m_last_element
);

`include "matrix_multiply_small_macros.svh"

    typedef enum logic [1:0] {
        ST_LOAD,   // taking A and B words
        ST_RUN,    // issuing one MAC per cycle while the output slot is free
        ST_DRAIN   // waiting for the final result word to leave
    } state_t;

    state_t state_reg;

    // Load side
    mms_pkg::cnt_t  load_count_reg;
    mms_pkg::cnt_t  right_rel;
    logic           load_accept;
    logic           load_right;

    // Sequencer counters: k walks the dot product, c the column, r the row.
    mms_pkg::idx_t  r_reg;
    mms_pkg::idx_t  c_reg;
    mms_pkg::idx_t  k_reg;
    mms_pkg::addr_t a_addr_reg;   // r*DIM + k
    mms_pkg::addr_t a_base_reg;   // r*DIM
    mms_pkg::addr_t b_addr_reg;   // k*DIM + c

    // Operand stores, read port registered
    mms_pkg::elem_t left_mem  [mms_pkg::CELLS];
    mms_pkg::elem_t right_mem [mms_pkg::CELLS];
    mms_pkg::elem_t a_rd_reg;
    mms_pkg::elem_t b_rd_reg;

    // Pipe tags
    mms_pkg::mms_tag_t issue_tag;
    mms_pkg::mms_tag_t rd_tag_reg;
    mms_pkg::mms_tag_t mac_tag;
    mms_pkg::acc_t     mac_sum;

    // Output register
    logic              m_valid_reg;
    mms_pkg::acc_t     m_value_reg;
    mms_pkg::idx_t     m_row_reg;
    mms_pkg::idx_t     m_col_reg;
    logic              m_last_reg;
    logic [mms_pkg::IDX_W+1:0] row_ext;
    logic [mms_pkg::IDX_W+1:0] col_ext;

    logic adv;       // whole compute pipe moves when the output slot is free
    logic run_last;  // issuing the final MAC of the matrix

    // Check helpers
    logic load_done;   // final B word taken
    logic last_taken;  // final product word leaves
    logic out_corner;  // output word sits at the bottom-right corner

    assign adv         = !m_valid_reg || m_ready;
    assign s_ready     = (state_reg == ST_LOAD);
    assign load_accept = s_valid && s_ready;
    assign load_right  = (load_count_reg >= mms_pkg::CNT_CELLS);
    assign right_rel   = load_count_reg - mms_pkg::CNT_CELLS;
    assign run_last    = (r_reg == mms_pkg::IDX_MAX) && (c_reg == mms_pkg::IDX_MAX)
                      && (k_reg == mms_pkg::IDX_MAX);

    assign load_done   = load_accept && (load_count_reg == mms_pkg::CNT_LAST);
    assign last_taken  = m_valid_reg && m_ready && m_last_reg;
    assign out_corner  = (m_row_reg == mms_pkg::IDX_MAX) && (m_col_reg == mms_pkg::IDX_MAX);

    always_comb begin
        issue_tag.valid     = (state_reg == ST_RUN);
        issue_tag.first     = (k_reg == '0);
        issue_tag.last_k    = (k_reg == mms_pkg::IDX_MAX);
        issue_tag.row       = r_reg;
        issue_tag.col       = c_reg;
        issue_tag.last_elem = (r_reg == mms_pkg::IDX_MAX) && (c_reg == mms_pkg::IDX_MAX);
    end

    // Stores: written while loading, read by the sequencer
    always_ff @(posedge aclk) begin
        if (load_accept) begin
            if (load_right) begin
                right_mem[right_rel[mms_pkg::ADDR_W-1:0]] <= s_element_value;
            end else begin
                left_mem[load_count_reg[mms_pkg::ADDR_W-1:0]] <= s_element_value;
            end
        end
        if (adv) begin
            a_rd_reg <= left_mem[a_addr_reg];
            b_rd_reg <= right_mem[b_addr_reg];
        end
    end

    mms_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (adv),
        .in_tag  (rd_tag_reg),
        .a_in    (a_rd_reg),
        .b_in    (b_rd_reg),
        .out_tag (mac_tag),
        .sum     (mac_sum)
    );

    // Sequencer, pipe tag and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_LOAD;
            load_count_reg <= '0;
            rd_tag_reg     <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_LOAD: begin
                    if (load_accept) begin
                        if (load_count_reg == mms_pkg::CNT_LAST) begin
                            load_count_reg <= '0;
                            state_reg      <= ST_RUN;
                            r_reg          <= '0;
                            c_reg          <= '0;
                            k_reg          <= '0;
                            a_addr_reg     <= '0;
                            a_base_reg     <= '0;
                            b_addr_reg     <= '0;
                        end else begin
                            load_count_reg <= load_count_reg + 1'b1;
                        end
                    end
                end
                ST_RUN: begin
                    if (adv) begin
                        if (k_reg != mms_pkg::IDX_MAX) begin
                            k_reg      <= k_reg + 1'b1;
                            a_addr_reg <= a_addr_reg + 1'b1;
                            b_addr_reg <= b_addr_reg + mms_pkg::DIM_ADDR;
                        end else begin
                            k_reg <= '0;
                            if (c_reg != mms_pkg::IDX_MAX) begin
                                c_reg      <= c_reg + 1'b1;
                                a_addr_reg <= a_base_reg;
                                b_addr_reg <= mms_pkg::addr_t'(c_reg) + 1'b1;
                            end else begin
                                c_reg      <= '0;
                                a_addr_reg <= a_base_reg + mms_pkg::DIM_ADDR;
                                a_base_reg <= a_base_reg + mms_pkg::DIM_ADDR;
                                b_addr_reg <= '0;
                                r_reg      <= r_reg + 1'b1;
                            end
                        end
                        if (run_last) begin
                            state_reg <= ST_DRAIN;
                        end
                    end
                end
                ST_DRAIN: begin
                    if (m_valid_reg && m_ready && m_last_reg) begin
                        state_reg <= ST_LOAD;
                    end
                end
                default: begin
                    state_reg <= ST_LOAD;
                end
            endcase

            if (adv) begin
                rd_tag_reg  <= issue_tag;
                m_valid_reg <= mac_tag.valid && mac_tag.last_k;
            end
        end
    end

    // Result payload, loaded when a dot product completes
    always_ff @(posedge aclk) begin
        if (adv && mac_tag.valid && mac_tag.last_k) begin
            m_value_reg <= mac_sum;
            m_row_reg   <= mac_tag.row;
            m_col_reg   <= mac_tag.col;
            m_last_reg  <= mac_tag.last_elem;
        end
    end

    // Index fields are 2 bits wide; wrap or zero-extend from the counter width
    assign row_ext = {2'b00, m_row_reg};
    assign col_ext = {2'b00, m_col_reg};

    assign m_valid         = m_valid_reg;
    assign m_product_value = m_value_reg;
    assign m_row_index     = row_ext[1:0];
    assign m_col_index     = col_ext[1:0];
    assign m_last_element  = m_last_reg;

    // Checks
    `MMS_ASSERT_SAME(a_no_load_with_result, m_valid_reg, !s_ready, "result pending while loading")
    `MMS_ASSERT_NEXT(a_back_to_load, last_taken, s_ready, "no return to load")
    `MMS_ASSERT_NEXT(a_start_run, load_done, state_reg == ST_RUN, "compute did not start")
    `MMS_ASSERT_SAME(a_last_is_corner, m_valid_reg && m_last_reg, out_corner, "last flag off corner")

endmodule

// ===== rtl/mms_mac.sv =====
// Shared multiply-accumulate unit: registered 16x16 product, then accumulate.
// Depends on mms_pkg.
module mms_mac (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  mms_pkg::mms_tag_t in_tag,
    input  mms_pkg::elem_t    a_in,
    input  mms_pkg::elem_t    b_in,
    output mms_pkg::mms_tag_t out_tag,
    output mms_pkg::acc_t     sum
);

    mms_pkg::prod_t    prod_reg;
    mms_pkg::mms_tag_t tag_reg;
    mms_pkg::acc_t     acc_reg;
    mms_pkg::acc_t     acc_next;

    // Accumulator wraps at 33 bits, same as masking the full sum.
    always_comb begin
        if (tag_reg.first) begin
            acc_next = mms_pkg::acc_t'(prod_reg);
        end else begin
            acc_next = acc_reg + mms_pkg::acc_t'(prod_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg <= '0;
        end else if (en) begin
            tag_reg <= in_tag;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= a_in * b_in;
            if (tag_reg.valid) begin
                acc_reg <= acc_next;
            end
        end
    end

    assign out_tag = tag_reg;
    assign sum     = acc_next;

endmodule
